### sv/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

   localparam int ByteW = 8;
   localparam int UnitW = 16;

   // decode phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;   // no sequence pending
   localparam logic [1:0] PH_TWO   = 2'd1;   // two-byte lead held
   localparam logic [1:0] PH_THREE = 2'd2;   // three-byte lead held
   localparam logic [1:0] PH_FULL  = 2'd3;   // three-byte lead and second held

   // byte class masks and patterns
   localparam logic [ByteW-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [ByteW-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [ByteW-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [ByteW-1:0] LEAD3_PAT  = 8'hE0;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             last_byte;
   } in_beat_type;

   typedef struct packed {
      logic [UnitW-1:0] code_unit;
      logic             unit_valid;
      logic             string_end;
   } out_beat_type;

   typedef struct packed {
      logic         emit;
      out_beat_type beat;
   } dec_result_type;

endpackage

### sv/u2u_in_stage.sv
// ----------------------------------------------------------------------------
// u2u_in_stage
// Input register: holds one byte beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module u2u_in_stage
   import u2u_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  in_beat_type req_beat,
   input  logic        advance,
   output logic        beat_valid,
   output in_beat_type beat
);

   logic        valid_ff;
   logic        valid_in;
   in_beat_type beat_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

### sv/u2u_decode.sv
// ----------------------------------------------------------------------------
// u2u_decode
// Sequence state and decode logic; updates state when a beat is consumed.
// ----------------------------------------------------------------------------
module u2u_decode
   import u2u_pkg::*;
#(
   parameter int MAX_UNITS = 63
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  in_beat_type    beat,
   output dec_result_type result
);

   localparam int CountW = $clog2(MAX_UNITS + 1);
   localparam logic [CountW-1:0] MaxCount = CountW'(MAX_UNITS);

   logic [1:0]        phase_ff, phase_in;
   logic [ByteW-1:0]  lead_ff, lead_in;
   logic [ByteW-1:0]  second_ff, second_in;
   logic [CountW-1:0] count_ff, count_in;

   logic [ByteW-1:0]  b;
   logic              last;
   logic              have;
   logic              keep;
   logic [UnitW-1:0]  unit;

   assign b    = beat.in_byte;
   assign last = beat.last_byte;

   always_comb begin
      have      = 1'b0;
      unit      = '0;
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (!b[ByteW-1]) begin
               unit = UnitW'(b);
               have = 1'b1;
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
               lead_in  = b;
               phase_in = PH_TWO;
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
               lead_in  = b;
               phase_in = PH_THREE;
            end
         end
         PH_TWO: begin
            unit     = {5'b0, lead_ff[4:0], b[5:0]};
            have     = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_THREE: begin
            if (last) begin
               // truncated sequence: byte re-read as a lead
               if (!b[ByteW-1]) begin
                  unit = UnitW'(b);
                  have = 1'b1;
               end
               phase_in = PH_IDLE;
            end else begin
               second_in = b;
               phase_in  = PH_FULL;
            end
         end
         PH_FULL: begin
            unit     = {lead_ff[3:0], second_ff[5:0], b[5:0]};
            have     = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      keep     = have && (count_ff < MaxCount);
      count_in = keep ? count_ff + 1'b1 : count_ff;
      if (last) begin
         phase_in = PH_IDLE;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

   assign result.emit            = keep || last;
   assign result.beat.code_unit  = keep ? unit : '0;
   assign result.beat.unit_valid = keep;
   assign result.beat.string_end = last;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> phase_ff == PH_IDLE && count_ff == '0)
      else $error("state not cleared after string end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("unit count beyond limit");

   a_full_from_three: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FULL && $past(phase_ff) != PH_FULL |-> $past(phase_ff) == PH_THREE)
      else $error("second byte held without three-byte lead");

endmodule

### sv/u2u_out_stage.sv
// ----------------------------------------------------------------------------
// u2u_out_stage
// Result register: holds one code unit beat until the sink takes it.
// ----------------------------------------------------------------------------
module u2u_out_stage
   import u2u_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  out_beat_type load_beat,
   output logic         can_load,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output out_beat_type rsp_beat
);

   logic         valid_ff;
   logic         valid_in;
   out_beat_type beat_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= load_beat;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_beat   = beat_ff;

endmodule

### sv/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 (BMP) decoder with a per-string unit limit.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle, sustained, with no gaps needed between
// strings. A byte goes through an input register, the decode logic and a
// result register; a unit is loaded into the result register when its
// closing byte leaves the input register. Bytes that complete no unit give no
// beat, except the last byte of a string, which always gives one beat with
// tlast set. Units past MAX_UNITS in one string are dropped. Backpressure on
// the result side stalls the input only when a beat is waiting to be loaded.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
   import u2u_pkg::*;
#(
   parameter int MAX_UNITS = 63
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tuser,   // unit_valid
   output logic        rsp_tlast    // string_end
);

   in_beat_type    req_beat;
   in_beat_type    cur_beat;
   logic           cur_valid;
   logic           advance;
   logic           can_load;
   dec_result_type result;
   out_beat_type   rsp_beat;

   assign req_beat.in_byte   = req_tdata;
   assign req_beat.last_byte = req_tlast;

   assign advance = cur_valid && (!result.emit || can_load);

   u2u_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_beat   (req_beat),
      .advance    (advance),
      .beat_valid (cur_valid),
      .beat       (cur_beat)
   );

   u2u_decode #(
      .MAX_UNITS (MAX_UNITS)
   ) u_dec (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .beat   (cur_beat),
      .result (result)
   );

   u2u_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.emit),
      .load_beat  (result.beat),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_tdata = rsp_beat.code_unit;
   assign rsp_tuser = rsp_beat.unit_valid;
   assign rsp_tlast = rsp_beat.string_end;

   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("empty beat that does not close a string");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result beat overwritten");

endmodule

### tb/utf8_to_utf16_decoder_test.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_test
// Self-checking bench for the streaming UTF-8 to UTF-16 decoder. UTF-8 bytes
// are sent as strings, first a few hand-picked ones (byte extremes,
// overlong and maximal sequences, skipped leads and stray bytes, sequences
// cut short at string end) and then random strings. The random strings are
// mostly well formed, with some noise, some cut short and a few long enough
// to hit the per-string unit limit. Each accepted byte runs through a
// bit-true decoder model, and every result beat is checked against the
// oldest predicted unit. Both sides idle at random, the receiver holds off
// once for a long stretch, and the sender drains the block now and then.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_test;
   import u2u_pkg::*;

   localparam int UNIT_LIMIT = 63;
   localparam int ITEMS      = 1700;
   localparam int SETTLE     = 8;
   localparam int HOLD_AT    = 200;
   localparam int HOLD_LEN   = 300;
   localparam int WATCHDOG   = 2000;

   typedef logic [7:0] byte_seq_type [$];

   typedef struct {
      in_beat_type beat;
      int          gap_after;
      bit          drain;
   } send_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] code_unit
   logic        rsp_tuser;           // unit_valid
   logic        rsp_tlast;           // string_end

   send_item_type utf8_bytes_q [$];
   out_beat_type  expected_units_q [$];

   // decoder model state
   logic [1:0] dec_phase = PH_IDLE;
   logic [7:0] held_lead = 8'h00;
   logic [7:0] held_second = 8'h00;
   int         units_kept = 0;

   send_item_type offered;
   bit           give;
   int           gap_left = 0;
   int           quiet_cnt = 0;
   out_beat_type want;
   bit           take;
   bit           rx_calm = 1'b0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           results_seen = 0;
   int           errors = 0;
   int           idle_cycles = 0;

   utf8_to_utf16_decoder #(.MAX_UNITS(UNIT_LIMIT)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_len(int zero_pct);
      if ($urandom_range(0, 99) < zero_pct) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void decode_byte(in_beat_type b);
      logic [15:0]  unit;
      logic         have;
      out_beat_type o;
      unit = '0;
      have = 1'b0;
      case (dec_phase)
         PH_IDLE: begin
            if (b.in_byte < 8'h80) begin
               unit = {8'h00, b.in_byte};
               have = 1'b1;
            end else if ((b.in_byte & LEAD2_MASK) == LEAD2_PAT) begin
               held_lead = b.in_byte;
               dec_phase = PH_TWO;
            end else if ((b.in_byte & LEAD3_MASK) == LEAD3_PAT) begin
               held_lead = b.in_byte;
               dec_phase = PH_THREE;
            end
         end
         PH_TWO: begin
            unit = {5'b0, held_lead[4:0], b.in_byte[5:0]};
            have = 1'b1;
            dec_phase = PH_IDLE;
         end
         PH_THREE: begin
            if (b.last_byte) begin
               if (b.in_byte < 8'h80) begin
                  unit = {8'h00, b.in_byte};
                  have = 1'b1;
               end
               dec_phase = PH_IDLE;
            end else begin
               held_second = b.in_byte;
               dec_phase = PH_FULL;
            end
         end
         default: begin
            unit = {held_lead[3:0], held_second[5:0], b.in_byte[5:0]};
            have = 1'b1;
            dec_phase = PH_IDLE;
         end
      endcase
      o.unit_valid = have && (units_kept < UNIT_LIMIT);
      if (o.unit_valid) units_kept++;
      o.code_unit  = o.unit_valid ? unit : 16'h0000;
      o.string_end = b.last_byte;
      if (o.unit_valid || b.last_byte) expected_units_q.push_back(o);
      if (b.last_byte) begin
         dec_phase   = PH_IDLE;
         held_lead   = 8'h00;
         held_second = 8'h00;
         units_kept  = 0;
      end
   endfunction

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 99) < 85) return 8'h80 | 8'($urandom_range(0, 63));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void add_char(ref byte_seq_type s, input int ascii_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ascii_pct) begin
         s.push_back(8'($urandom_range(1, 127)));
      end else if (r < ascii_pct + (100 - ascii_pct) / 2) begin
         s.push_back({3'b110, 5'($urandom_range(0, 31))});
         s.push_back(cont_byte());
      end else begin
         s.push_back({4'b1110, 4'($urandom_range(0, 15))});
         s.push_back(cont_byte());
         s.push_back(cont_byte());
      end
   endfunction

   function automatic int queue_string(byte_seq_type s, bit calm, bit drain);
      send_item_type it;
      foreach (s[i]) begin
         it.beat.in_byte   = s[i];
         it.beat.last_byte = (i == s.size() - 1);
         it.gap_after      = calm ? 0 : idle_len(65);
         it.drain          = drain && (i == 0);
         utf8_bytes_q.push_back(it);
      end
      return s.size();
   endfunction

   // stimulus
   initial begin
      byte_seq_type s;
      int        sent;
      int        n;
      int        r;
      int        str_idx;
      sent = 0;
      str_idx = 0;
      s = '{8'h01, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
            8'hEF, 8'hBF, 8'hBF, 8'h80, 8'hF0, 8'hFF};
      void'(queue_string(s, 1'b0, 1'b0));
      s = '{8'hC3};
      void'(queue_string(s, 1'b0, 1'b0));
      s = '{8'hE2};
      void'(queue_string(s, 1'b0, 1'b0));
      s = '{8'hE2, 8'h41};
      void'(queue_string(s, 1'b0, 1'b0));
      s = '{8'hE2, 8'hA9};
      void'(queue_string(s, 1'b0, 1'b0));
      s = '{8'hC3, 8'hA9};
      void'(queue_string(s, 1'b0, 1'b1));

      while (sent < ITEMS) begin
         s = {};
         str_idx++;
         r = $urandom_range(0, 99);
         if (str_idx % 60 == 30) begin
            n = $urandom_range(64, 90);
            repeat (n) add_char(s, 70);
         end else if (r < 70) begin
            n = $urandom_range(1, 12);
            repeat (n) add_char(s, 40);
         end else if (r < 82) begin
            n = $urandom_range(0, 6);
            repeat (n) add_char(s, 40);
            case ($urandom_range(0, 2))
               0: s.push_back({3'b110, 5'($urandom_range(0, 31))});
               1: s.push_back({4'b1110, 4'($urandom_range(0, 15))});
               default: begin
                  s.push_back({4'b1110, 4'($urandom_range(0, 15))});
                  s.push_back(8'($urandom_range(1, 255)));
               end
            endcase
         end else begin
            n = $urandom_range(1, 10);
            repeat (n) s.push_back(8'($urandom_range(1, 255)));
         end
         sent += queue_string(s, $urandom_range(0, 99) < 30, str_idx % 40 == 0);
      end

      while (utf8_bytes_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_units_q.size() != 0 || rsp_tvalid) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_byte(offered.beat);
         if (expected_units_q.size() != 0 || req_tvalid) quiet_cnt = 0;
         else if (quiet_cnt < SETTLE) quiet_cnt++;
         if (!req_tvalid || req_tready) begin
            give = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (utf8_bytes_q.size() != 0) begin
               if (!utf8_bytes_q[0].drain || quiet_cnt >= SETTLE) begin
                  offered   = utf8_bytes_q.pop_front();
                  gap_left  = offered.gap_after;
                  give      = 1'b1;
                  req_tdata <= offered.beat.in_byte;
                  req_tlast <= offered.beat.last_byte;
               end
            end
            req_tvalid <= give;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units_q.size() == 0) begin
               $display("%0t: unexpected beat unit=%h valid=%b end=%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               want = expected_units_q.pop_front();
               if (rsp_tdata !== want.code_unit || rsp_tuser !== want.unit_valid ||
                   rsp_tlast !== want.string_end) begin
                  $display("%0t: mismatch expected %h/%b/%b got %h/%b/%b",
                           $time, want.code_unit, want.unit_valid, want.string_end,
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  errors++;
               end
            end
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            if (results_seen % 150 == 0) rx_calm = !rx_calm;
         end
         if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            take = 1'b0;
         end else begin
            stall_left = idle_len(rx_calm ? 100 : 80);
            take = (stall_left == 0);
            if (!take) stall_left--;
         end
         rsp_tready <= take;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule

### files.f
sv/u2u_pkg.sv
sv/u2u_in_stage.sv
sv/u2u_decode.sv
sv/u2u_out_stage.sv
sv/utf8_to_utf16_decoder.sv
tb/utf8_to_utf16_decoder_test.sv
